// ===== src/mmc_pkg.sv =====
// Shared types, widths and constants of the magnetometer min/max calibrator.
package mmc_pkg;

   localparam int AXES_DEFAULT      = 3;
   localparam int FRAC_BITS_DEFAULT = 12;

   // Fixed field widths.
   localparam int CAL_AXES  = 3;
   localparam int RAW_W     = 16;
   localparam int CAL_W     = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   // Arithmetic widths: numerator 2*raw - max - min, span max - min,
   // magnitude of the numerator, doubled span and quotient steps.
   localparam int NUM_W = RAW_W + 3;
   localparam int DEN_W = RAW_W + 1;
   localparam int MAG_W = RAW_W + 1;
   localparam int D2_W  = RAW_W + 1;
   localparam int QB    = CAL_W + 1;

   localparam logic signed [RAW_W-1:0] INIT_MAX_RST = 16'sd500;
   localparam logic signed [RAW_W-1:0] INIT_MIN_RST = -16'sd500;

   localparam logic signed [CAL_W-1:0] SAT_POS   = 16'sh7fff;
   localparam logic signed [CAL_W-1:0] SAT_NEG   = 16'sh8000;
   localparam logic [QB-1:0]           SAT_POS_Q = 17'd32767;
   localparam logic [QB-1:0]           SAT_NEG_Q = 17'd32768;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEARN = 3'd0,
      CSR_MAX_X = 3'd1,
      CSR_MAX_Y = 3'd2,
      CSR_MAX_Z = 3'd3,
      CSR_MIN_X = 3'd4,
      CSR_MIN_Y = 3'd5,
      CSR_MIN_Z = 3'd6
   } csr_reg_type;

   // Control from the top level to every lane.
   typedef struct packed {
      logic start;
      logic restart;
      logic learn;
      logic release_res;
   } lane_ctl_type;

   // Status and result of one lane.
   typedef struct packed {
      logic                    idle;
      logic                    done;
      logic                    clip;
      logic                    degen;
      logic signed [CAL_W-1:0] cal;
   } lane_stat_type;

endpackage

// ===== src/mmc_lane.sv =====
// One axis lane: min/max tracking and a bit-serial restoring divider.
module mmc_lane #(
   parameter int FRAC_BITS = mmc_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  mmc_pkg::lane_ctl_type                  ctl,
   input  logic signed [mmc_pkg::RAW_W-1:0]       raw,
   input  logic signed [mmc_pkg::RAW_W-1:0]       init_max,
   input  logic signed [mmc_pkg::RAW_W-1:0]       init_min,
   output mmc_pkg::lane_stat_type                 stat
);
   import mmc_pkg::*;

   // Dividend is (mag << (FRAC_BITS+1)) + span.
   localparam int DW    = MAG_W + FRAC_BITS + 2;
   localparam int UPW   = DW - QB;
   localparam int CW    = (UPW > D2_W) ? UPW : D2_W;
   localparam int CNT_W = $clog2(QB);

   typedef enum logic [2:0] {
      ST_IDLE, ST_PREP, ST_SCALE, ST_CHECK, ST_ITER, ST_FIN, ST_DONE
   } state_type;

   state_type                state_ff, state_in;
   logic signed [RAW_W-1:0]  max_ff, max_in, min_ff, min_in, raw_ff, raw_in;
   logic signed [NUM_W-1:0]  num_ff, num_in;
   logic signed [DEN_W-1:0]  den_ff, den_in;
   logic [DW-1:0]            dvd_ff, dvd_in;
   logic [D2_W-1:0]          d2_ff, d2_in, rem_ff, rem_in;
   logic [QB-1:0]            sh_ff, sh_in, q_ff, q_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     neg_ff, neg_in, clip_ff, clip_in, degen_ff, degen_in;
   logic signed [CAL_W-1:0]  cal_ff, cal_in;

   logic signed [NUM_W-1:0]  mag_full;
   logic [UPW-1:0]           upper;
   logic [D2_W:0]            trial, diff;
   logic                     ge;

   always_comb begin
      state_in = state_ff;
      max_in   = max_ff;
      min_in   = min_ff;
      raw_in   = raw_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      dvd_in   = dvd_ff;
      d2_in    = d2_ff;
      rem_in   = rem_ff;
      sh_in    = sh_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      clip_in  = clip_ff;
      degen_in = degen_ff;
      cal_in   = cal_ff;

      mag_full = num_ff[NUM_W-1] ? -num_ff : num_ff;
      upper    = dvd_ff[DW-1:QB];
      trial    = {rem_ff, sh_ff[QB-1]};
      diff     = trial - {1'b0, d2_ff};
      ge       = (trial >= {1'b0, d2_ff});

      case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               if (ctl.restart) begin
                  max_in   = init_max;
                  min_in   = init_min;
                  cal_in   = '0;
                  clip_in  = 1'b0;
                  degen_in = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  raw_in = raw;
                  if (ctl.learn && (raw > max_ff)) max_in = raw;
                  if (ctl.learn && (raw < min_ff)) min_in = raw;
                  state_in = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            num_in   = (NUM_W'(raw_ff) <<< 1) - NUM_W'(max_ff) - NUM_W'(min_ff);
            den_in   = DEN_W'(max_ff) - DEN_W'(min_ff);
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            if (den_ff <= 0) begin
               cal_in   = '0;
               clip_in  = 1'b0;
               degen_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               neg_in   = num_ff[NUM_W-1];
               dvd_in   = DW'({mag_full[MAG_W-1:0], {(FRAC_BITS+1){1'b0}}})
                        + DW'(den_ff[DEN_W-2:0]);
               d2_in    = {den_ff[DEN_W-2:0], 1'b0};
               degen_in = 1'b0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // A quotient too large for the step count saturates at once.
            if (CW'(upper) >= CW'(d2_ff)) begin
               clip_in  = 1'b1;
               cal_in   = neg_ff ? SAT_NEG : SAT_POS;
               state_in = ST_DONE;
            end else begin
               rem_in   = D2_W'(upper);
               sh_in    = dvd_ff[QB-1:0];
               q_in     = '0;
               cnt_in   = CNT_W'(QB - 1);
               state_in = ST_ITER;
            end
         end
         ST_ITER: begin
            rem_in = ge ? diff[D2_W-1:0] : trial[D2_W-1:0];
            sh_in  = sh_ff << 1;
            q_in   = {q_ff[QB-2:0], ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (neg_ff) begin
               clip_in = (q_ff > SAT_NEG_Q);
               cal_in  = (q_ff > SAT_NEG_Q) ? SAT_NEG : CAL_W'(QB'(0) - q_ff);
            end else begin
               clip_in = (q_ff > SAT_POS_Q);
               cal_in  = (q_ff > SAT_POS_Q) ? SAT_POS : CAL_W'(q_ff);
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (ctl.release_res) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         max_ff   <= INIT_MAX_RST;
         min_ff   <= INIT_MIN_RST;
      end else begin
         state_ff <= state_in;
         max_ff   <= max_in;
         min_ff   <= min_in;
      end
      raw_ff   <= raw_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      dvd_ff   <= dvd_in;
      d2_ff    <= d2_in;
      rem_ff   <= rem_in;
      sh_ff    <= sh_in;
      q_ff     <= q_in;
      cnt_ff   <= cnt_in;
      neg_ff   <= neg_in;
      clip_ff  <= clip_in;
      degen_ff <= degen_in;
      cal_ff   <= cal_in;
   end

   assign stat.idle  = (state_ff == ST_IDLE);
   assign stat.done  = (state_ff == ST_DONE);
   assign stat.clip  = clip_ff;
   assign stat.degen = degen_ff;
   assign stat.cal   = cal_ff;

   // The running remainder stays below the divisor through every step.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ITER) |-> (rem_ff < d2_ff))
      else $error("lane remainder not below divisor");

   // A degenerate axis reports zero and never a clipped value.
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && degen_ff) |-> (cal_ff == '0 && !clip_ff))
      else $error("degenerate axis with nonzero result");

   // The top level only starts a lane that has finished its last beat.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> (state_ff == ST_IDLE))
      else $error("lane started while busy");

endmodule

// ===== src/mmc_merge.sv =====
// Merge stage: combines lane results and flags into the result register.
module mmc_merge #(
   parameter int AXES = mmc_pkg::AXES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mmc_pkg::lane_stat_type              lane_stat [AXES],
   output logic                                release_res,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [mmc_pkg::CAL_W-1:0]    rsp_cal [mmc_pkg::CAL_AXES],
   output logic                                rsp_clipped,
   output logic                                rsp_degenerate
);
   import mmc_pkg::*;

   logic                    valid_ff, valid_in;
   logic signed [CAL_W-1:0] cal_ff [CAL_AXES];
   logic signed [CAL_W-1:0] cal_src [CAL_AXES];
   logic                    clip_ff, degen_ff;
   logic                    all_done, any_clip, any_degen;

   always_comb begin
      all_done  = 1'b1;
      any_clip  = 1'b0;
      any_degen = 1'b0;
      for (int i = 0; i < AXES; i++) begin
         all_done  = all_done & lane_stat[i].done;
         any_clip  = any_clip | lane_stat[i].clip;
         any_degen = any_degen | lane_stat[i].degen;
      end
   end

   // Axes without a lane always report zero.
   for (genvar i = 0; i < CAL_AXES; i++) begin : g_src
      if (i < AXES) begin : g_lane
         assign cal_src[i] = lane_stat[i].cal;
      end else begin : g_none
         assign cal_src[i] = '0;
      end
   end

   // A finished result moves out as soon as the register is free or drains.
   assign release_res = all_done && (!valid_ff || !rsp_stall);
   assign valid_in    = release_res || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (release_res) begin
         cal_ff   <= cal_src;
         clip_ff  <= any_clip;
         degen_ff <= any_degen;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_cal        = cal_ff;
   assign rsp_clipped    = clip_ff;
   assign rsp_degenerate = degen_ff;

endmodule

// ===== src/magnetometer_minmax_calibrator_core.sv =====
// Top level of the three-axis magnetometer min/max calibrator.
// Each sample beat returns one result beat: per axis (2*raw - max - min)/(max - min)
// as signed fixed point with FRAC_BITS fraction bits, rounded to nearest with ties
// away from zero and saturated to 16 bits, plus clipped and degenerate flags. One lane
// per axis tracks that axis's limits and divides with a restoring divider that settles
// one of 17 quotient bits per cycle. The block takes no new beat until every lane has
// handed its result on; a restart beat returns a result beat of zeros.
// An axis whose limits are equal or inverted skips the divider, as does one whose
// quotient overflows 17 bits, and the result beat leaves when the slowest lane is done.
// The result register lets a new beat enter while the previous result waits.
// Starting limits written through the register port take effect at the next restart.
module magnetometer_minmax_calibrator_core #(
   parameter int AXES      = mmc_pkg::AXES_DEFAULT,
   parameter int FRAC_BITS = mmc_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_kind,
   input  logic signed [mmc_pkg::RAW_W-1:0]     req_raw_x,
   input  logic signed [mmc_pkg::RAW_W-1:0]     req_raw_y,
   input  logic signed [mmc_pkg::RAW_W-1:0]     req_raw_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [mmc_pkg::CAL_W-1:0]     rsp_cal_x,
   output logic signed [mmc_pkg::CAL_W-1:0]     rsp_cal_y,
   output logic signed [mmc_pkg::CAL_W-1:0]     rsp_cal_z,
   output logic                                 rsp_clipped,
   output logic                                 rsp_degenerate,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mmc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mmc_pkg::CSR_DAT_W-1:0]        csr_data
);
   import mmc_pkg::*;

   logic                    learn_ff;
   logic signed [RAW_W-1:0] init_max_ff [CAL_AXES];
   logic signed [RAW_W-1:0] init_min_ff [CAL_AXES];
   logic signed [RAW_W-1:0] raw_arr [CAL_AXES];
   lane_stat_type           lane_stat [AXES];
   lane_ctl_type            ctl;
   logic signed [CAL_W-1:0] cal_arr [CAL_AXES];
   logic                    release_res, lanes_idle, start;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         learn_ff <= 1'b0;
         for (int i = 0; i < CAL_AXES; i++) begin
            init_max_ff[i] <= INIT_MAX_RST;
            init_min_ff[i] <= INIT_MIN_RST;
         end
      end else if (csr_valid && csr_ready) begin
         case (csr_reg_type'(csr_index))
            CSR_LEARN: learn_ff       <= csr_data[0];
            CSR_MAX_X: init_max_ff[0] <= csr_data;
            CSR_MAX_Y: init_max_ff[1] <= csr_data;
            CSR_MAX_Z: init_max_ff[2] <= csr_data;
            CSR_MIN_X: init_min_ff[0] <= csr_data;
            CSR_MIN_Y: init_min_ff[1] <= csr_data;
            CSR_MIN_Z: init_min_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      lanes_idle = 1'b1;
      for (int i = 0; i < AXES; i++) lanes_idle = lanes_idle & lane_stat[i].idle;
   end

   assign req_stall = !lanes_idle;
   assign start     = req_valid && !req_stall;

   assign ctl.start       = start;
   assign ctl.restart     = req_kind;
   assign ctl.learn       = learn_ff;
   assign ctl.release_res = release_res;

   assign raw_arr[0] = req_raw_x;
   assign raw_arr[1] = req_raw_y;
   assign raw_arr[2] = req_raw_z;

   for (genvar i = 0; i < AXES; i++) begin : g_lane
      mmc_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .raw      (raw_arr[i]),
         .init_max (init_max_ff[i]),
         .init_min (init_min_ff[i]),
         .stat     (lane_stat[i])
      );
   end

   mmc_merge #(
      .AXES (AXES)
   ) u_merge (
      .clock          (clock),
      .reset          (reset),
      .lane_stat      (lane_stat),
      .release_res    (release_res),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cal        (cal_arr),
      .rsp_clipped    (rsp_clipped),
      .rsp_degenerate (rsp_degenerate)
   );

   assign rsp_cal_x = cal_arr[0];
   assign rsp_cal_y = cal_arr[1];
   assign rsp_cal_z = cal_arr[2];

   // An accepted beat keeps the input side stalled until the lanes hand their results on.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start |=> req_stall)
      else $error("input taken while lanes still working");

endmodule

// ===== tb/magnetometer_minmax_calibrator_core_tb.sv =====
// Self-checking testbench for the three-axis magnetometer min/max calibrator core.
module magnetometer_minmax_calibrator_core_tb;
   import mmc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int AXES = AXES_DEFAULT;
   localparam int FRAC = FRAC_BITS_DEFAULT;

   localparam logic KIND_SAMPLE  = 1'b0;
   localparam logic KIND_RESTART = 1'b1;

   // No register sits at this index, so writes to it must be ignored.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   typedef struct packed {
      logic signed [CAL_W-1:0] cal_x;
      logic signed [CAL_W-1:0] cal_y;
      logic signed [CAL_W-1:0] cal_z;
      logic                    clipped;
      logic                    degenerate;
   } cal_result_type;

   class calibration_scoreboard;
      bit                      learn_on;
      logic signed [RAW_W-1:0] start_max[3];
      logic signed [RAW_W-1:0] start_min[3];
      int                      lim_max[3];
      int                      lim_min[3];
      cal_result_type          expected_cal_q[$];
      int                      errors;

      function new();
         learn_on = 1'b0;
         errors   = 0;
         foreach (start_max[a]) begin
            start_max[a] = INIT_MAX_RST;
            start_min[a] = INIT_MIN_RST;
         end
         reload_limits();
      endfunction

      function void reload_limits();
         foreach (lim_max[a]) begin
            lim_max[a] = start_max[a];
            lim_min[a] = start_min[a];
         end
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] data);
         case (idx)
            CSR_LEARN: learn_on = data[0];
            CSR_MAX_X, CSR_MAX_Y, CSR_MAX_Z: start_max[idx - CSR_MAX_X] = data;
            CSR_MIN_X, CSR_MIN_Y, CSR_MIN_Z: start_min[idx - CSR_MIN_X] = data;
            default: ;
         endcase
      endfunction

      // (2*raw - max - min) / (max - min) in fixed point, rounded half away from zero.
      function logic signed [CAL_W-1:0] scale_axis(int raw, int mx, int mn,
                                                   inout bit clip, inout bit degen);
         longint num, mag, span, q;
         if (mx <= mn) begin
            degen = 1'b1;
            return '0;
         end
         num  = 2 * longint'(raw) - mx - mn;
         mag  = (num < 0) ? -num : num;
         span = longint'(mx) - mn;
         q    = ((mag << (FRAC + 1)) + span) / (2 * span);
         if (num < 0) begin
            if (q > 32768) begin
               q    = 32768;
               clip = 1'b1;
            end
            return CAL_W'(-q);
         end
         if (q > 32767) begin
            q    = 32767;
            clip = 1'b1;
         end
         return CAL_W'(q);
      endfunction

      function void note_beat(logic kind, logic signed [RAW_W-1:0] x,
                              logic signed [RAW_W-1:0] y, logic signed [RAW_W-1:0] z);
         cal_result_type          r;
         int                      raw[3];
         logic signed [CAL_W-1:0] cal[3];
         bit                      clip, degen;
         r     = '0;
         clip  = 1'b0;
         degen = 1'b0;
         if (kind == KIND_RESTART) begin
            reload_limits();
            expected_cal_q.push_back(r);
            return;
         end
         raw[0] = x;
         raw[1] = y;
         raw[2] = z;
         for (int a = 0; a < 3; a++) begin
            cal[a] = '0;
            if (a < AXES) begin
               if (learn_on) begin
                  if (raw[a] > lim_max[a]) lim_max[a] = raw[a];
                  if (raw[a] < lim_min[a]) lim_min[a] = raw[a];
               end
               cal[a] = scale_axis(raw[a], lim_max[a], lim_min[a], clip, degen);
            end
         end
         r.cal_x      = cal[0];
         r.cal_y      = cal[1];
         r.cal_z      = cal[2];
         r.clipped    = clip;
         r.degenerate = degen;
         expected_cal_q.push_back(r);
      endfunction

      task report(string msg);
         errors++;
         $display("ERROR at %0t ns: %s", $time, msg);
      endtask

      task compare_field(string name, logic signed [CAL_W-1:0] got,
                         logic signed [CAL_W-1:0] want);
         if (got !== want)
            report($sformatf("%s is %0d, expected %0d", name, got, want));
      endtask

      task check_beat(cal_result_type got);
         cal_result_type want;
         if (expected_cal_q.size() == 0) begin
            report("result beat arrived with nothing expected");
            return;
         end
         want = expected_cal_q.pop_front();
         compare_field("cal_x", got.cal_x, want.cal_x);
         compare_field("cal_y", got.cal_y, want.cal_y);
         compare_field("cal_z", got.cal_z, want.cal_z);
         compare_field("clipped", got.clipped, want.clipped);
         compare_field("degenerate", got.degenerate, want.degenerate);
      endtask

      function int pending();
         return expected_cal_q.size();
      endfunction
   endclass

   logic                    clock          = 1'b0;
   logic                    reset          = 1'b1;
   logic                    req_valid      = 1'b0;
   logic                    req_stall;
   logic                    req_kind       = KIND_SAMPLE;
   logic signed [RAW_W-1:0] req_raw_x      = '0;
   logic signed [RAW_W-1:0] req_raw_y      = '0;
   logic signed [RAW_W-1:0] req_raw_z      = '0;
   logic                    rsp_valid;
   logic                    rsp_stall      = 1'b0;
   logic signed [CAL_W-1:0] rsp_cal_x;
   logic signed [CAL_W-1:0] rsp_cal_y;
   logic signed [CAL_W-1:0] rsp_cal_z;
   logic                    rsp_clipped;
   logic                    rsp_degenerate;
   logic                    csr_valid      = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index      = '0;
   logic [CSR_DAT_W-1:0]    csr_data       = '0;

   int req_idle_pct = 0;
   int rsp_idle_pct = 0;

   calibration_scoreboard sb = new();

   magnetometer_minmax_calibrator_core uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_raw_x      (req_raw_x),
      .req_raw_y      (req_raw_y),
      .req_raw_z      (req_raw_z),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cal_x      (rsp_cal_x),
      .rsp_cal_y      (rsp_cal_y),
      .rsp_cal_z      (rsp_cal_z),
      .rsp_clipped    (rsp_clipped),
      .rsp_degenerate (rsp_degenerate),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_beat(req_kind, req_raw_x, req_raw_y, req_raw_z);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_beat({rsp_cal_x, rsp_cal_y, rsp_cal_z, rsp_clipped, rsp_degenerate});
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   // Valid stays high from one beat to the next unless the sender idles.
   task automatic send_beat(input logic kind, input logic signed [RAW_W-1:0] x,
                            input logic signed [RAW_W-1:0] y,
                            input logic signed [RAW_W-1:0] z);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_raw_x <= x;
      req_raw_y <= y;
      req_raw_z <= z;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_restart();
      send_beat(KIND_RESTART, RAW_W'($urandom), RAW_W'($urandom), RAW_W'($urandom));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DAT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
   endtask

   task automatic load_settings(input bit learn, input int max_v[3], input int min_v[3]);
      write_csr(CSR_LEARN, {15'($urandom), learn});
      for (int a = 0; a < 3; a++) begin
         write_csr(CSR_IDX_W'(CSR_MAX_X + a), CSR_DAT_W'(max_v[a]));
         write_csr(CSR_IDX_W'(CSR_MIN_X + a), CSR_DAT_W'(min_v[a]));
      end
      write_csr(CSR_UNUSED, CSR_DAT_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [RAW_W-1:0] pick_raw(input int axis);
      int lo, hi;
      lo = sb.lim_min[axis];
      hi = sb.lim_max[axis];
      case ($urandom_range(9))
         0, 1, 2: return RAW_W'($urandom);
         3: begin
            case ($urandom_range(4))
               0: return 16'sh7fff;
               1: return 16'sh8000;
               2: return '0;
               3: return RAW_W'(lo);
               default: return RAW_W'(hi);
            endcase
         end
         4: return RAW_W'(int'($urandom_range(64)) - 32);
         default: begin
            if (hi > lo)
               return RAW_W'(lo + int'($urandom_range(hi - lo)));
            return RAW_W'($urandom);
         end
      endcase
   endfunction

   task automatic run_phase(input int sender_pct, input int receiver_pct, input bit learn,
                            input int max_v[3], input int min_v[3], input int count);
      drain_results();
      req_idle_pct = sender_pct;
      rsp_idle_pct = receiver_pct;
      load_settings(learn, max_v, min_v);
      send_restart();
      for (int n = 0; n < count; n++) begin
         // Now and then hold off until the pipeline is empty.
         if ($urandom_range(249) == 0)
            drain_results();
         if ($urandom_range(99) < 4)
            send_restart();
         else
            send_beat(KIND_SAMPLE, pick_raw(0), pick_raw(1), pick_raw(2));
      end
   endtask

   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int mx[3], mn[3];

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset limits of plus and minus 500 with learning off.
      send_beat(KIND_SAMPLE, 0, 0, 0);
      send_beat(KIND_SAMPLE, 500, -500, 250);
      send_beat(KIND_SAMPLE, 16'sh7fff, 16'sh8000, 1);
      send_beat(KIND_SAMPLE, -1, 1, 499);
      send_restart();

      // A span of 16384 puts exact halves on odd raw values; z has equal limits.
      drain_results();
      mx = '{8192, 8192, 100};
      mn = '{-8192, -8192, 100};
      load_settings(1'b0, mx, mn);
      send_restart();
      send_beat(KIND_SAMPLE, 1, -1, 5);
      send_beat(KIND_SAMPLE, 3, -3, 0);
      send_beat(KIND_SAMPLE, -6, 10, 16'sh7fff);

      // Inverted extreme limits with learning: the first sample collapses each span.
      drain_results();
      mx = '{-32768, -32768, -32768};
      mn = '{32767, 32767, 32767};
      load_settings(1'b1, mx, mn);
      send_restart();
      send_beat(KIND_SAMPLE, 0, 16'sh7fff, 16'sh8000);
      send_beat(KIND_SAMPLE, 100, 16'sh8000, 16'sh7fff);
      send_beat(KIND_SAMPLE, 50, 0, 0);
      send_beat(KIND_SAMPLE, -200, 12345, -1);
      send_beat(KIND_SAMPLE, 16'sh7fff, 16'sh8000, 0);

      // Narrow starting limits, learning on.
      foreach (mx[a]) begin
         mx[a] = $urandom_range(2000);
         mn[a] = -int'($urandom_range(2000));
      end
      run_phase(13, 68, 1'b1, mx, mn, 450);

      // Full-range x, random wide y, very narrow z for heavy clipping; learning off.
      mx[0] = 32767;
      mn[0] = -32768;
      mx[1] = $urandom_range(32767);
      mn[1] = -int'($urandom_range(32768));
      mn[2] = int'($urandom_range(1000)) - 500;
      mx[2] = mn[2] + int'($urandom_range(16, 1));
      run_phase(68, 13, 1'b0, mx, mn, 450);

      mx = '{-32768, -32768, -32768};
      mn = '{32767, 32767, 32767};
      run_phase(0, 0, 1'b1, mx, mn, 450);

      // Inverted x, equal y and a span of one on z, learning off.
      mx[0] = int'($urandom_range(1000)) - 1000;
      mn[0] = mx[0] + 1 + int'($urandom_range(500));
      mx[1] = int'($urandom_range(65535)) - 32768;
      mn[1] = mx[1];
      mn[2] = int'($urandom_range(200)) - 100;
      mx[2] = mn[2] + 1;
      run_phase(0, 0, 1'b0, mx, mn, 450);

      drain_results();
      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
